[src/vdm_pkg.sv]
// ----------------------------------------------------------------------------
// vdm_pkg
// shared widths, codes and types of the vector distance metric unit
// ----------------------------------------------------------------------------
package vdm_pkg;

  localparam int ELEM_W = 16;   // signed q1.15 element
  localparam int SQ_W   = 45;   // squared difference sum, unsigned
  localparam int DOT_W  = 44;   // dot product sum, signed
  localparam int NORM_W = 43;   // squared norm sums, unsigned
  localparam int DIST_W = 46;   // result word, signed
  localparam int PROD_W = 32;   // one product of two elements
  localparam int SQRT_W = 44;   // working width of the root unit
  localparam int ROOT_W = 22;   // root of a norm sum
  localparam int NUM_W  = 60;   // |dot| scaled by one in q2.16
  localparam int REM_W  = 45;   // divider remainder
  localparam int Q16_W  = 18;   // cosine result before extension

  localparam int DEF_MAX_DIM     = 4096;
  localparam int DEF_QUEUE_DEPTH = 4;

  typedef logic [1:0] metric_t;
  localparam metric_t MET_L2  = 2'd0;
  localparam metric_t MET_COS = 2'd1;
  localparam metric_t MET_IP  = 2'd2;

  localparam logic [Q16_W-1:0] Q16_ONE = 18'd65536;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_CHK,
    ST_SQA,
    ST_SQB,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } vdm_state_t;

  // one queued word between front and back
  typedef struct packed {
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    logic                     use_pair;  // below the element limit
    logic                     last;
  } vdm_item_t;

endpackage

[src/vector_distance_metric_unit.sv]
// ----------------------------------------------------------------------------
// vector_distance_metric_unit
// streaming distance between two vectors: squared l2, cosine, inner product
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata: elem_a, elem_b; tlast: last
//  out_    | out | out_tvalid/out_tready| tdata: distance; tuser: zero_norm
//  cfg_    | in  | cfg_valid/cfg_ready  | data: metric, always ready
//
//  element pairs are taken one per cycle while the queue has room; the
//  product stage and the saturating adders keep pace with that
//  after the last pair, squared l2, inner product and zero-norm cosine go
//  from the check state to output; cosine otherwise runs two 22-step roots and
//  a 60-step divider, one step a cycle; pairs queue meanwhile, then stall input
//  rst_n is synchronous: clears sums, counters, queue and metric
//  an unread result holds in the output register while the next vector
//  accumulates
// ----------------------------------------------------------------------------
module vector_distance_metric_unit import vdm_pkg::*; #(
  parameter int MAX_DIM     = DEF_MAX_DIM,      // pairs summed per vector
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH   // front-to-back queue words
) (
  input  logic                clk,
  input  logic                rst_n,
  // input words
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,    // [15:0] elem_a, [31:16] elem_b
  input  logic                in_tlast,    // last pair of the vectors
  // result words
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [47:0]         out_tdata,   // [45:0] distance, [47:46] pad
  output logic [0:0]          out_tuser,   // [0] zero_norm
  // metric register
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data     // metric
);

  vdm_item_t         q_in, q_head;
  logic              q_push, q_pop, q_empty, q_full;
  metric_t           metric;
  logic [DIST_W-1:0] res_dist;
  logic              zero;

  // front: handshake, element limit, metric register
  vdm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in),
    .metric    (metric)
  );

  // decouples intake from the finishing sequence
  vdm_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back: sums, finishing arithmetic, output register
  vdm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .metric     (metric),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_dist   (res_dist),
    .out_zero   (zero)
  );

  assign out_tdata = {2'b00, res_dist};
  assign out_tuser = zero;

endmodule

[src/vdm_front.sv]
// ----------------------------------------------------------------------------
// vdm_front
// accepts input words, marks pairs past the element limit, holds metric
// ----------------------------------------------------------------------------
module vdm_front import vdm_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2*ELEM_W-1:0]   in_tdata,
  input  logic                  in_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  metric_t               cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output vdm_item_t             q_item,
  output metric_t               metric
);

  localparam int CNT_W = $clog2(MAX_DIM + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  metric_t          metric_r;
  logic             use_pair;

  assign in_tready = !q_full;
  assign cfg_ready = 1'b1;
  assign q_push    = in_tvalid && !q_full;
  assign use_pair  = cnt_r < CNT_W'(MAX_DIM);
  assign metric    = metric_r;

  assign q_item.a        = in_tdata[ELEM_W-1:0];
  assign q_item.b        = in_tdata[2*ELEM_W-1:ELEM_W];
  assign q_item.use_pair = use_pair;
  assign q_item.last     = in_tlast;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_tlast) cnt_nxt = '0;
      else if (use_pair) cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      metric_r <= MET_L2;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_valid) metric_r <= cfg_data;
    end
  end

endmodule

[src/vdm_fifo.sv]
// ----------------------------------------------------------------------------
// vdm_fifo
// short queue of element pairs between front and back
// ----------------------------------------------------------------------------
module vdm_fifo import vdm_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH   // power of two, at least 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  vdm_item_t push_item,
  input  logic      pop,
  output vdm_item_t head,
  output logic      empty,
  output logic      full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  vdm_item_t         slot_r [DEPTH];
  logic [AW-1:0]     wp_r, rp_r;
  logic [CW-1:0]     cnt_r;

  assign empty = cnt_r == '0;
  assign full  = cnt_r == CW'(DEPTH);
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[src/vdm_back.sv]
// ----------------------------------------------------------------------------
// vdm_back
// products, saturating sums, cosine sequencer and output register
// ----------------------------------------------------------------------------
module vdm_back import vdm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  vdm_item_t           head,
  input  logic                empty,
  output logic                pop,
  input  metric_t             metric,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [DIST_W-1:0]   out_dist,
  output logic                out_zero
);

  localparam logic [SQ_W-1:0]   SQ_MAX   = {SQ_W{1'b1}};
  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};
  localparam logic [DOT_W-1:0]  DOT_MAX  = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic [DOT_W-1:0]  DOT_MIN  = {1'b1, {(DOT_W-1){1'b0}}};
  localparam logic [SQRT_W-1:0] BIT_TOP  = SQRT_W'(1) << (NORM_W - 1);
  localparam logic [4:0]        SQ_LAST  = 5'(ROOT_W - 1);
  localparam logic [5:0]        DIV_LAST = 6'(NUM_W - 1);

  vdm_state_t state_r, state_nxt;

  // product stage
  logic                     pv_r, pl_r, pu_r;
  logic [PROD_W-1:0]        sqt_r, nat_r, nbt_r;
  logic signed [PROD_W-1:0] dpt_r;

  // running sums
  logic [SQ_W-1:0]          sq_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic [NORM_W-1:0]        na_r, nb_r;

  // cosine datapath
  logic [SQRT_W-1:0]        sx_r, sr_r, sbit_r;
  logic [4:0]               scnt_r;
  logic [ROOT_W-1:0]        sa_r, sb_r;
  logic [SQRT_W-1:0]        den_r;
  logic                     neg_r;
  logic [REM_W-1:0]         rem_r;
  logic [NUM_W-1:0]         q_r;
  logic [5:0]               dcnt_r;

  // result held for the output register
  logic [DIST_W-1:0]        res_r;
  logic                     rzero_r;
  logic                     ovalid_r;
  logic [DIST_W-1:0]        odist_r;
  logic                     ozero_r;

  logic signed [ELEM_W:0]   diff;
  logic [ELEM_W:0]          ad, ua, ub;
  logic [SQ_W:0]            sq_sum;
  logic [NORM_W:0]          na_sum, nb_sum;
  logic signed [DOT_W:0]    dot_sum;
  logic [SQRT_W-1:0]        s_trial, sx_nxt, sr_nxt;
  logic                     s_ge;
  logic [REM_W-1:0]         d_trial;
  logic                     d_ge;
  logic [DOT_W-1:0]         dot_abs;
  logic [16:0]              mag;
  logic                     acc_last, out_free;

  assign pop      = (state_r == ST_ACC) && !empty && !(pv_r && pl_r);
  assign acc_last = pv_r && pl_r;
  assign out_free = !ovalid_r || out_tready;

  assign out_tvalid = ovalid_r;
  assign out_dist   = odist_r;
  assign out_zero   = ozero_r;

  // element magnitudes for the squared terms
  always_comb begin
    diff = {head.a[ELEM_W-1], head.a} - {head.b[ELEM_W-1], head.b};
    ad   = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : diff;
    ua   = head.a[ELEM_W-1] ? (ELEM_W+1)'(-{1'b1, head.a}) : {1'b0, head.a};
    ub   = head.b[ELEM_W-1] ? (ELEM_W+1)'(-{1'b1, head.b}) : {1'b0, head.b};
  end

  // saturating sum updates
  always_comb begin
    sq_sum  = {1'b0, sq_r} + (SQ_W+1)'(sqt_r);
    na_sum  = {1'b0, na_r} + (NORM_W+1)'(nat_r);
    nb_sum  = {1'b0, nb_r} + (NORM_W+1)'(nbt_r);
    dot_sum = {dot_r[DOT_W-1], dot_r} + (DOT_W+1)'(dpt_r);
  end

  // one root step
  always_comb begin
    s_trial = sr_r + sbit_r;
    s_ge    = sx_r >= s_trial;
    sx_nxt  = s_ge ? sx_r - s_trial : sx_r;
    sr_nxt  = s_ge ? (sr_r >> 1) + sbit_r : sr_r >> 1;
  end

  // one divide step
  always_comb begin
    d_trial = {rem_r[REM_W-2:0], q_r[NUM_W-1]};
    d_ge    = d_trial >= REM_W'(den_r);
    dot_abs = dot_r[DOT_W-1] ? DOT_W'(-dot_r) : dot_r;
    mag     = (q_r > NUM_W'(Q16_ONE)) ? Q16_ONE[16:0] : q_r[16:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACC: if (acc_last) state_nxt = ST_CHK;
      ST_CHK: begin
        if (metric == MET_COS && na_r != '0 && nb_r != '0) state_nxt = ST_SQA;
        else state_nxt = ST_OUT;
      end
      ST_SQA: if (scnt_r == SQ_LAST) state_nxt = ST_SQB;
      ST_SQB: if (scnt_r == SQ_LAST) state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: if (dcnt_r == DIV_LAST) state_nxt = ST_FIX;
      ST_FIX: state_nxt = ST_OUT;
      ST_OUT: if (out_free) state_nxt = ST_ACC;
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_ACC;
    else state_r <= state_nxt;
  end

  // products
  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else pv_r <= pop;
    if (pop) begin
      pl_r  <= head.last;
      pu_r  <= head.use_pair;
      sqt_r <= PROD_W'(ad[ELEM_W-1:0] * ad[ELEM_W-1:0]);
      nat_r <= PROD_W'(ua[ELEM_W-1:0] * ua[ELEM_W-1:0]);
      nbt_r <= PROD_W'(ub[ELEM_W-1:0] * ub[ELEM_W-1:0]);
      dpt_r <= head.a * head.b;
    end
  end

  // sums, cleared when a result leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r  <= '0;
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
    end else if (state_r == ST_OUT && out_free) begin
      sq_r  <= '0;
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
    end else if (pv_r && pu_r) begin
      sq_r <= sq_sum[SQ_W] ? SQ_MAX : sq_sum[SQ_W-1:0];
      na_r <= na_sum[NORM_W] ? NORM_MAX : na_sum[NORM_W-1:0];
      nb_r <= nb_sum[NORM_W] ? NORM_MAX : nb_sum[NORM_W-1:0];
      if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) dot_r <= dot_sum[DOT_W] ? DOT_MIN : DOT_MAX;
      else dot_r <= dot_sum[DOT_W-1:0];
    end
  end

  // cosine sequencer datapath and result
  always_ff @(posedge clk) begin
    case (state_r)
      ST_CHK: begin
        sx_r   <= SQRT_W'(na_r);
        sr_r   <= '0;
        sbit_r <= BIT_TOP;
        scnt_r <= '0;
        rzero_r <= 1'b0;
        if (metric == MET_COS) begin
          res_r   <= DIST_W'(Q16_ONE);
          rzero_r <= 1'b1;
        end else if (metric == MET_IP) begin
          res_r <= DIST_W'(-{{(DIST_W-DOT_W){dot_r[DOT_W-1]}}, dot_r});
        end else begin
          res_r <= DIST_W'(sq_r);
        end
      end
      ST_SQA: begin
        scnt_r <= scnt_r + 1'b1;
        if (scnt_r == SQ_LAST) begin
          sa_r   <= sr_nxt[ROOT_W-1:0];
          sx_r   <= SQRT_W'(nb_r);
          sr_r   <= '0;
          sbit_r <= BIT_TOP;
          scnt_r <= '0;
        end else begin
          sx_r   <= sx_nxt;
          sr_r   <= sr_nxt;
          sbit_r <= sbit_r >> 2;
        end
      end
      ST_SQB: begin
        scnt_r <= scnt_r + 1'b1;
        sx_r   <= sx_nxt;
        sr_r   <= sr_nxt;
        sbit_r <= sbit_r >> 2;
        if (scnt_r == SQ_LAST) sb_r <= sr_nxt[ROOT_W-1:0];
      end
      ST_MUL: begin
        den_r  <= SQRT_W'(sa_r * sb_r);
        neg_r  <= dot_r[DOT_W-1];
        q_r    <= {dot_abs[NUM_W-17:0], 16'd0};
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      ST_DIV: begin
        dcnt_r <= dcnt_r + 1'b1;
        rem_r  <= d_ge ? d_trial - REM_W'(den_r) : d_trial;
        q_r    <= {q_r[NUM_W-2:0], d_ge};
      end
      ST_FIX: begin
        rzero_r <= 1'b0;
        if (neg_r) res_r <= DIST_W'(Q16_ONE + Q16_W'(mag));
        else res_r <= DIST_W'(Q16_ONE - Q16_W'(mag));
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
    if (state_r == ST_OUT && out_free) begin
      odist_r <= res_r;
      ozero_r <= rzero_r;
    end
  end

endmodule

[src/vdm_checker.sv]
// ----------------------------------------------------------------------------
// vdm_checker
// port-level checks of the vector distance metric unit
// ----------------------------------------------------------------------------
module vdm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // zero norm forces one in q2.16
  a_zero_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[45:0] == 46'd65536)
    else $error("zero norm without unit distance");

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind vector_distance_metric_unit vdm_checker u_vdm_checker (.*);

[sim/vector_distance_metric_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_distance_metric_unit_tb
// drives random and corner-case vector pairs under each metric, predicts the
// distance and zero-norm flag per vector and checks every result word
// ----------------------------------------------------------------------------
module vector_distance_metric_unit_tb;
  import vdm_pkg::*;

  localparam int MAX_DIM_TB = 4096;
  localparam logic [SQ_W-1:0]   SQ_SAT   = {SQ_W{1'b1}};
  localparam logic [NORM_W-1:0] NORM_SAT = {NORM_W{1'b1}};
  localparam longint DOT_HI = (64'sd1 <<< (DOT_W-1)) - 1;
  localparam longint DOT_LO = -(64'sd1 <<< (DOT_W-1));
  localparam longint ONE_Q16 = 65536;

  typedef struct packed {
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    logic                     last;
  } pair_t;

  typedef struct packed {
    logic [DIST_W-1:0] dval;
    logic              zflag;
  } dist_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tlast = 1'b0, out_tready = 1'b0;
  logic [31:0] in_tdata = '0;
  logic in_tready, out_tvalid, cfg_ready;
  logic [47:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_data = '0;

  always #6 clk = ~clk;

  vector_distance_metric_unit dut (.*);

  // predictor state
  logic [SQ_W-1:0]   sq_acc;
  longint            dot_acc;
  logic [NORM_W-1:0] na_acc, nb_acc;
  int                pair_cnt;
  metric_t           cur_metric;

  pair_t pending[$];
  dist_t expected_dist[$];
  int errors = 0, mism = 0, n_results = 0, n_pairs = 0;
  bit quiet = 1'b0;
  bit in_taken = 1'b0;
  int in_gap = 0, out_gap = 0;

  function automatic longint root_floor(longint x);
    longint r, bitv;
    r = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > x) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >>> 1) + bitv;
      end else begin
        r = r >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return r;
  endfunction

  // runs one accepted pair through the sums, queues a distance on last
  task automatic predict_pair(pair_t p);
    longint a, b, d, s, ratio;
    logic [63:0] t;
    dist_t r;
    a = p.a;
    b = p.b;
    if (pair_cnt < MAX_DIM_TB) begin
      d = a - b;
      t = d * d;
      sq_acc = ({19'd0, sq_acc} + t > SQ_SAT) ? SQ_SAT : sq_acc + t[SQ_W-1:0];
      t = a * a;
      na_acc = ({21'd0, na_acc} + t > NORM_SAT) ? NORM_SAT : na_acc + t[NORM_W-1:0];
      t = b * b;
      nb_acc = ({21'd0, nb_acc} + t > NORM_SAT) ? NORM_SAT : nb_acc + t[NORM_W-1:0];
      s = dot_acc + a * b;
      dot_acc = (s > DOT_HI) ? DOT_HI : (s < DOT_LO) ? DOT_LO : s;
      pair_cnt++;
    end
    if (!p.last) return;
    r.zflag = 1'b0;
    if (cur_metric == MET_COS) begin
      if (na_acc == 0 || nb_acc == 0) begin
        r.zflag = 1'b1;
        s = ONE_Q16;
      end else begin
        ratio = (dot_acc * ONE_Q16) / (root_floor(na_acc) * root_floor(nb_acc));
        if (ratio > ONE_Q16) ratio = ONE_Q16;
        if (ratio < -ONE_Q16) ratio = -ONE_Q16;
        s = ONE_Q16 - ratio;
      end
    end else if (cur_metric == MET_IP) begin
      s = -dot_acc;
    end else begin
      s = sq_acc;
    end
    r.dval = s[DIST_W-1:0];
    expected_dist.push_back(r);
    sq_acc = '0; dot_acc = 0; na_acc = '0; nb_acc = '0; pair_cnt = 0;
  endtask

  // input words are taken at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_pair(pending.pop_front());
      n_pairs++;
      in_taken = 1'b1;
    end
  end

  // driver: inputs change on the falling edge, a waiting word holds
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 19) == 0) begin
          in_gap = $urandom_range(1, 15);
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= {pending[0].b, pending[0].a};
          in_tlast <= pending[0].last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      in_taken = 1'b0;
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        out_gap = $urandom_range(1, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: result words sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_dist.size() == 0) begin
        errors++;
        if (mism < 10) $display("unexpected result word %h", out_tdata);
        mism++;
      end else begin
        dist_t e;
        e = expected_dist.pop_front();
        if (out_tdata[DIST_W-1:0] !== e.dval || out_tuser[0] !== e.zflag) begin
          errors++;
          if (mism < 10)
            $display("result %0d: expected dist %h zero %b, got dist %h zero %b",
                     n_results, e.dval, e.zflag, out_tdata[DIST_W-1:0], out_tuser[0]);
          mism++;
        end
      end
    end
  end

  task automatic add_vec(int len, int kind);
    pair_t p;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: begin p.a = $urandom; p.b = $urandom; end
        1: begin p.a = 16'sh8000; p.b = 16'sh7fff; end   // max difference
        2: begin p.a = '0; p.b = $urandom; end           // zero norm on a
        3: begin p.a = $urandom; p.b = '0; end           // zero norm on b
        4: begin p.a = $urandom; p.b = p.a; end          // parallel vectors
        5: begin p.a = $urandom; p.b = -p.a; end         // opposite vectors
        default: begin p.a = 16'sh8000; p.b = 16'sh8000; end
      endcase
      p.last = (i == len - 1);
      pending.push_back(p);
    end
  endtask

  task automatic write_metric(metric_t m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_metric = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending.size() > 0 || in_tvalid || expected_dist.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    metric_t plan[6];
    plan = '{MET_L2, MET_COS, MET_IP, 2'd3, MET_COS, MET_IP};
    sq_acc = '0; dot_acc = 0; na_acc = '0; nb_acc = '0; pair_cnt = 0;
    cur_metric = MET_L2;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // directed: reset metric then a max-difference single pair, equal extremes, random pairs
    add_vec(1, 1); add_vec(3, 6); add_vec(2, 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_metric(plan[ph]);
      if (ph < 3) begin
        for (int k = 1; k <= 6; k++) add_vec(k == 6 ? 1 : 3, k);
      end
      if (ph == 4) quiet = 1'b1;
      for (int v = 0; v < 22; v++)
        add_vec($urandom_range(1, 20), ($urandom_range(0, 7) < 5) ? 0 : $urandom_range(1, 6));
      drain();
    end
    $display("covered %0d pairs and %0d distances across all metrics", n_pairs, n_results);
    $display("including zero-norm, extreme-element and single-pair vectors");
    if (errors == 0 && expected_dist.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
